// ===== design/mhtq_pkg.sv =====
// Shared types, codes and helpers for the min-heap timer queue.
// No dependencies; every design file imports this package.
package mhtq_pkg;

   localparam int DefCapacity = 16;
   localparam int MaxResults  = 16;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      RSP_INSERTED  = 3'd0,
      RSP_CANCELED  = 3'd1,
      RSP_FIRED     = 3'd2,
      RSP_IDLE_TICK = 3'd3,
      RSP_CLEARED   = 3'd4
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_LAST_WT,
      S_SD_START,
      S_SD_RDL,
      S_SD_RDR,
      S_SU_RD,
      S_SU_CMP,
      S_FIN,
      S_TICK_RD,
      S_TICK_CHK,
      S_TICK_END
   } state_type;

   typedef struct packed {
      logic [31:0] expiry;
      logic [31:0] handle;
      logic [31:0] tag;
   } entry_type;

   function automatic logic [4:0] low5(input logic [31:0] v);
      low5 = v[4:0];
   endfunction

endpackage

// ===== design/mhtq_mem.sv =====
// Heap entry storage: one write port, one read port, registered read data.
// Depends on mhtq_pkg for the entry type.
module mhtq_mem
   import mhtq_pkg::*;
#(
   parameter int Depth = DefCapacity,
   parameter int AW    = $clog2(DefCapacity)
) (
   input  logic      clock,
   input  logic      we,
   input  logic [AW-1:0] waddr,
   input  entry_type wdata,
   input  logic [AW-1:0] raddr,
   output entry_type rdata
);

   entry_type mem [Depth];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/min_heap_timer_queue_top.sv =====
// Channel   Ports                                   Handshake
// request   req_type, req_delay_ms, req_user_tag,   start high while busy low
//           req_cancel_handle
// response  rsp_kind, rsp_out_handle, rsp_out_tag,  rsp_valid, one cycle per beat
//           rsp_status, rsp_pending, rsp_last
//
// Items run one at a time through a sequencer around a single heap memory.
// Clear, full insert and trivial cancel answer straight from idle; insert sifts
// up; cancel searches the heap entry by entry and then sifts; each fired timer of
// a tick is followed by a sift. The one memory read port serialises these steps.
// Reset is synchronous and empties the queue; the receiver cannot stall.
// Depends on mhtq_pkg and mhtq_mem.
module min_heap_timer_queue_top
   import mhtq_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_delay_ms,
   input  logic [31:0] req_user_tag,
   input  logic [31:0] req_cancel_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_out_handle,
   output logic [31:0] rsp_out_tag,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_pending,
   output logic        rsp_last
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = IW + 2;

   state_type     state_ff, state_in;
   req_kind_type  op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   hcnt_ff, hcnt_in;
   logic [31:0]   now_ff, now_in;
   entry_type     cur_ff, cur_in;
   entry_type     left_ff, left_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] spos_ff, spos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   want_ff, want_in;
   logic          rok_ff, rok_in;
   logic [4:0]    fire_ff, fire_in;
   logic          held_ff, held_in;
   logic [31:0]   hold_h_ff, hold_h_in;
   logic [31:0]   hold_t_ff, hold_t_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_kind_type  rsp_kind_ff, rsp_kind_in;
   logic [31:0]   rsp_handle_ff, rsp_handle_in;
   logic [31:0]   rsp_tag_ff, rsp_tag_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [4:0]    rsp_pend_ff, rsp_pend_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata, mem_rdata;

   logic [XW-1:0] count_x, lidx_x, ridx_x, idx1_x;
   logic [IW-1:0] pos_m1, parent;
   logic [CW-1:0] count_m1;
   logic [31:0]   hnext;
   entry_type     best;
   logic [XW-1:0] best_x;
   logic          best_moved;

   mhtq_mem #(.Depth(CAPACITY), .AW(IW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign count_x  = XW'(count_ff);
   assign lidx_x   = {1'b0, pos_ff, 1'b1};
   assign ridx_x   = lidx_x + 1'b1;
   assign idx1_x   = XW'(idx_ff) + 1'b1;
   assign pos_m1   = pos_ff - 1'b1;
   assign parent   = IW'(pos_m1 >> 1);
   assign count_m1 = count_ff - 1'b1;
   assign hnext    = (hcnt_ff + 32'd1 == 32'd0) ? 32'd1 : hcnt_ff + 32'd1;

   // Smallest of the moving entry and the children just read.
   always_comb begin
      best       = cur_ff;
      best_x     = XW'(pos_ff);
      best_moved = 1'b0;
      if (left_ff.expiry < best.expiry) begin
         best       = left_ff;
         best_x     = lidx_x;
         best_moved = 1'b1;
      end
      if (rok_ff && mem_rdata.expiry < best.expiry) begin
         best       = mem_rdata;
         best_x     = ridx_x;
         best_moved = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hcnt_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= 1'b0;
         fire_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hcnt_ff      <= hcnt_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         fire_ff      <= fire_in;
      end
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      pos_ff        <= pos_in;
      spos_ff       <= spos_in;
      idx_ff        <= idx_in;
      want_ff       <= want_in;
      rok_ff        <= rok_in;
      hold_h_ff     <= hold_h_in;
      hold_t_ff     <= hold_t_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      hcnt_in       = hcnt_ff;
      now_in        = now_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      spos_in       = spos_ff;
      idx_in        = idx_ff;
      want_in       = want_ff;
      rok_in        = rok_ff;
      fire_in       = fire_ff;
      held_in       = held_ff;
      hold_h_in     = hold_h_ff;
      hold_t_in     = hold_t_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = '0;
      rsp_tag_in    = '0;
      rsp_status_in = ST_OK;
      rsp_pend_in   = low5(32'(count_ff));
      rsp_last_in   = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cur_ff;
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_kind_type'(req_type);
               case (req_kind_type'(req_type))
                  REQ_INSERT: begin
                     if (32'(count_ff) >= 32'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = RSP_INSERTED;
                        rsp_status_in = ST_FULL;
                     end else begin
                        hcnt_in  = hnext;
                        cur_in   = '{expiry: now_ff + req_delay_ms, handle: hnext,
                                     tag: req_user_tag};
                        pos_in   = IW'(count_ff);
                        count_in = count_ff + 1'b1;
                        state_in = S_SU_RD;
                     end
                  end
                  REQ_CANCEL: begin
                     if (req_cancel_handle == 32'd0 || count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = RSP_CANCELED;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        want_in  = req_cancel_handle;
                        idx_in   = '0;
                        state_in = S_SRCH_RD;
                     end
                  end
                  REQ_TICK: begin
                     now_in   = now_ff + 32'd1;
                     fire_in  = '0;
                     held_in  = 1'b0;
                     state_in = S_TICK_RD;
                  end
                  default: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RSP_CLEARED;
                     rsp_pend_in  = '0;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            mem_raddr = idx_ff;
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (mem_rdata.handle == want_ff) begin
               count_in = count_m1;
               if (XW'(idx_ff) < XW'(count_m1)) begin
                  mem_raddr = IW'(count_m1);
                  pos_in    = idx_ff;
                  spos_in   = idx_ff;
                  state_in  = S_LAST_WT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RSP_CANCELED;
                  rsp_pend_in  = low5(32'(count_m1));
                  state_in     = S_IDLE;
               end
            end else if (idx1_x >= count_x) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RSP_CANCELED;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_LAST_WT: begin
            cur_in   = mem_rdata;
            state_in = S_SD_START;
         end
         S_SD_START: begin
            if (lidx_x >= count_x) begin
               // Hole reached a leaf; a cancel that never moved sifts up next.
               if (op_ff == REQ_CANCEL && pos_ff == spos_ff) begin
                  state_in = S_SU_RD;
               end else begin
                  mem_we   = 1'b1;
                  state_in = S_FIN;
               end
            end else begin
               mem_raddr = IW'(lidx_x);
               state_in  = S_SD_RDL;
            end
         end
         S_SD_RDL: begin
            left_in   = mem_rdata;
            rok_in    = ridx_x < count_x;
            mem_raddr = IW'(ridx_x);
            state_in  = S_SD_RDR;
         end
         S_SD_RDR: begin
            if (best_moved) begin
               mem_we    = 1'b1;
               mem_wdata = best;
               pos_in    = IW'(best_x);
               state_in  = S_SD_START;
            end else if (op_ff == REQ_CANCEL && pos_ff == spos_ff) begin
               state_in = S_SU_RD;
            end else begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end
         end
         S_SU_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               mem_raddr = parent;
               state_in  = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            mem_we = 1'b1;
            if (cur_ff.expiry >= mem_rdata.expiry) begin
               state_in = S_FIN;
            end else begin
               mem_wdata = mem_rdata;
               pos_in    = parent;
               state_in  = S_SU_RD;
            end
         end
         S_FIN: begin
            case (op_ff)
               REQ_INSERT: begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = RSP_INSERTED;
                  rsp_handle_in = hcnt_ff;
                  state_in      = S_IDLE;
               end
               REQ_CANCEL: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RSP_CANCELED;
                  state_in     = S_IDLE;
               end
               default: begin
                  state_in = S_TICK_RD;
               end
            endcase
         end
         S_TICK_RD: begin
            if (count_ff == '0 || 32'(fire_ff) >= 32'(MaxResults)) begin
               state_in = S_TICK_END;
            end else begin
               mem_raddr = '0;
               state_in  = S_TICK_CHK;
            end
         end
         S_TICK_CHK: begin
            if (mem_rdata.expiry <= now_ff) begin
               // A held beat goes out here only once we know another one follows.
               if (held_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = RSP_FIRED;
                  rsp_handle_in = hold_h_ff;
                  rsp_tag_in    = hold_t_ff;
                  rsp_last_in   = 1'b0;
               end
               held_in   = 1'b1;
               hold_h_in = mem_rdata.handle;
               hold_t_in = mem_rdata.tag;
               fire_in   = fire_ff + 1'b1;
               count_in  = count_m1;
               pos_in    = '0;
               spos_in   = '0;
               if (count_m1 != '0) begin
                  mem_raddr = IW'(count_m1);
                  state_in  = S_LAST_WT;
               end else begin
                  state_in = S_TICK_RD;
               end
            end else begin
               state_in = S_TICK_END;
            end
         end
         S_TICK_END: begin
            rsp_valid_in = 1'b1;
            if (held_ff) begin
               rsp_kind_in   = RSP_FIRED;
               rsp_handle_in = hold_h_ff;
               rsp_tag_in    = hold_t_ff;
            end else begin
               rsp_kind_in = RSP_IDLE_TICK;
            end
            held_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pending    = rsp_pend_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
